FILE: design/msf_pkg.sv
// Shared types and constants for the message slot FIFO.
// Used by msf_front, msf_back and the message_slot_fifo top level.
package msf_pkg;

   // Width of the message length field carried on the result channel.
   localparam int LEN_W = 7;

   typedef enum logic [1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_DROP = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_LONG  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_LAST,
      OP_POP,
      OP_DROP
   } op_kind_type;

   // One classified operation handed from the front end to the back end.
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
      logic        empty_msg;
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LEN,
      BK_STREAM
   } back_state_type;

endpackage

FILE: design/msf_front.sv
// Front end of the message slot FIFO: accepts request transactions, classifies
// them into operations and holds them in a two-entry queue. Depends on msf_pkg.
module msf_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_command,
   input  logic [7:0]      req_in_byte,
   input  logic            req_in_last,
   input  logic            req_in_empty_message,
   output logic            op_valid,
   input  logic            op_ready,
   output msf_pkg::op_type op
);
   import msf_pkg::*;

   op_type     q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] qcnt_ff, qcnt_in;
   op_type     cls;
   logic       cls_keep;
   logic       push, pop;

   always_comb begin
      cls.kind      = OP_PUSH;
      cls.data      = req_in_byte;
      cls.empty_msg = req_in_empty_message;
      cls_keep      = 1'b1;
      unique case (req_command)
         CMD_PUSH: cls.kind = req_in_last ? OP_LAST : OP_PUSH;
         CMD_POP:  cls.kind = OP_POP;
         CMD_DROP: cls.kind = OP_DROP;
         default:  cls_keep = 1'b0;  // Unused command code is taken and dropped.
      endcase
   end

   assign req_ready = (qcnt_ff != 2'd2);
   assign op_valid  = (qcnt_ff != 2'd0);
   assign op        = q_ff[rptr_ff];
   assign push      = req_valid && req_ready && cls_keep;
   assign pop       = op_valid && op_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      qcnt_in = qcnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         qcnt_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= cls;
      end
   end

endmodule

FILE: design/msf_back.sv
// Back end of the message slot FIFO: slot storage, ring pointers, message
// assembly and the registered result stage. Depends on msf_pkg.
module msf_back #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_MESSAGE = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               op_valid,
   output logic                               op_ready,
   input  msf_pkg::op_type                    op,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_byte_valid,
   output logic                               rsp_run_last,
   output logic [1:0]                         rsp_status,
   output logic [msf_pkg::LEN_W-1:0]          rsp_message_length,
   output logic                               rsp_queue_empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_message_count
);
   import msf_pkg::*;

   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LW = $clog2(MAX_MESSAGE + 1);
   localparam int AW = $clog2(QUEUE_DEPTH * MAX_MESSAGE);
   localparam logic [CW-1:0]    DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [LW-1:0]    MAXM_C  = LW'(MAX_MESSAGE);
   localparam logic [SW-1:0]    LAST_SLOT = SW'(QUEUE_DEPTH - 1);

   logic [7:0]       bytes_mem [QUEUE_DEPTH * MAX_MESSAGE];
   logic [LEN_W-1:0] lens_mem [QUEUE_DEPTH];
   logic [7:0]       rdata_ff;
   logic [LEN_W-1:0] lens_rdata_ff;

   back_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [SW-1:0]  rd_slot_ff, rd_slot_in;
   logic [SW-1:0]  wr_slot_ff, wr_slot_in;
   logic [LW-1:0]  fill_ff, fill_in;
   logic           over_ff, over_in;
   logic           fseen_ff, fseen_in;
   logic           drop_ff, drop_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  idx_ff, idx_in;
   logic [AW-1:0]  base_ff, base_in;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_bv_ff;
   logic             rsp_last_ff;
   status_type       rsp_status_ff;
   logic [LEN_W-1:0] rsp_len_ff;
   logic [CW-1:0]    rsp_count_ff;

   logic             out_can, emit;
   logic [7:0]       e_byte;
   logic             e_bv, e_last;
   status_type       e_status;
   logic [LEN_W-1:0] e_len;
   logic             store_try, commit, start_pop;
   logic             wr_en, len_wr_en, rd_en, lens_rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [LEN_W-1:0] len_wr_data;
   logic [LW-1:0]    len_clamp;
   logic             len_short, stream_last;

   assign out_can     = !rsp_valid_ff || rsp_ready;
   assign len_clamp   = (lens_rdata_ff > LEN_W'(MAX_MESSAGE)) ? MAXM_C : LW'(lens_rdata_ff);
   assign len_short   = drop_ff || (len_clamp == '0);
   assign stream_last = ((idx_ff + LW'(1)) == len_ff);

   always_comb begin
      op_ready    = 1'b0;
      emit        = 1'b0;
      e_byte      = 8'd0;
      e_bv        = 1'b0;
      e_last      = 1'b1;
      e_status    = ST_OK;
      e_len       = '0;
      store_try   = 1'b0;
      commit      = 1'b0;
      start_pop   = 1'b0;
      cnt_in      = cnt_ff;
      rd_slot_in  = rd_slot_ff;
      wr_slot_in  = wr_slot_ff;
      fill_in     = fill_ff;
      over_in     = over_ff;
      fseen_in    = fseen_ff;
      drop_in     = drop_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      base_in     = base_ff;
      wr_en       = 1'b0;
      wr_addr     = AW'(int'(wr_slot_ff) * MAX_MESSAGE + int'(fill_ff));
      len_wr_en   = 1'b0;
      len_wr_data = '0;
      rd_en       = 1'b0;
      rd_addr     = AW'(int'(rd_slot_ff) * MAX_MESSAGE);
      lens_rd_en  = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (op_valid) begin
               unique case (op.kind)
                  OP_PUSH: begin
                     op_ready  = 1'b1;
                     store_try = 1'b1;
                  end
                  OP_LAST: begin
                     if (out_can) begin
                        op_ready  = 1'b1;
                        store_try = !op.empty_msg;
                        commit    = 1'b1;
                     end
                  end
                  OP_POP, OP_DROP: begin
                     if (cnt_ff == '0) begin
                        if (out_can) begin
                           op_ready = 1'b1;
                           emit     = 1'b1;
                           e_status = ST_EMPTY;
                        end
                     end else begin
                        // Free the slot now; the bytes are read out over the
                        // following cycles before anything can overwrite them.
                        op_ready   = 1'b1;
                        start_pop  = 1'b1;
                        drop_in    = (op.kind == OP_DROP);
                        base_in    = rd_addr;
                        rd_en      = 1'b1;
                        lens_rd_en = 1'b1;
                        rd_slot_in = (rd_slot_ff == LAST_SLOT) ? '0 : rd_slot_ff + SW'(1);
                        cnt_in     = cnt_ff - CW'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_LEN: begin
            if (len_short) begin
               emit = out_can;
            end else begin
               len_in = len_clamp;
               idx_in = '0;
            end
         end
         BK_STREAM: begin
            if (out_can) begin
               emit   = 1'b1;
               e_byte = rdata_ff;
               e_bv   = 1'b1;
               e_last = stream_last;
               e_len  = LEN_W'(len_ff);
               idx_in = idx_ff + LW'(1);
               if (!stream_last) begin
                  rd_en   = 1'b1;
                  rd_addr = base_ff + AW'(idx_ff) + AW'(1);
               end
            end
         end
         default: ;
      endcase

      // Bytes arriving while the queue is full or past the slot size are not
      // stored; the flags make the final byte of the message reject it.
      if (store_try) begin
         if (cnt_ff >= DEPTH_C) begin
            fseen_in = 1'b1;
         end else if (fill_ff >= MAXM_C) begin
            over_in = 1'b1;
         end else if (!fseen_ff) begin
            wr_en   = 1'b1;
            fill_in = fill_ff + LW'(1);
         end
      end

      if (commit) begin
         emit = 1'b1;
         if (over_in) begin
            e_status = ST_LONG;
         end else if (fseen_in || cnt_ff >= DEPTH_C) begin
            e_status = ST_FULL;
         end else begin
            len_wr_en   = 1'b1;
            len_wr_data = LEN_W'(fill_in);
            wr_slot_in  = (wr_slot_ff == LAST_SLOT) ? '0 : wr_slot_ff + SW'(1);
            cnt_in      = cnt_ff + CW'(1);
         end
         fill_in  = '0;
         over_in  = 1'b0;
         fseen_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start_pop) state_in = BK_LEN;
         end
         BK_LEN: begin
            if (!len_short) state_in = BK_STREAM;
            else if (out_can) state_in = BK_IDLE;
         end
         BK_STREAM: begin
            if (out_can && stream_last) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         rd_slot_ff   <= '0;
         wr_slot_ff   <= '0;
         fill_ff      <= '0;
         over_ff      <= 1'b0;
         fseen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_slot_ff <= rd_slot_in;
         wr_slot_ff <= wr_slot_in;
         fill_ff    <= fill_in;
         over_ff    <= over_in;
         fseen_ff   <= fseen_in;
         if (out_can) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      drop_ff <= drop_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      base_ff <= base_in;
      if (out_can && emit) begin
         rsp_byte_ff   <= e_byte;
         rsp_bv_ff     <= e_bv;
         rsp_last_ff   <= e_last;
         rsp_status_ff <= e_status;
         rsp_len_ff    <= e_len;
         rsp_count_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bytes_mem[wr_addr] <= op.data;
      end
      if (rd_en) begin
         rdata_ff <= bytes_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_wr_en) begin
         lens_mem[wr_slot_ff] <= len_wr_data;
      end
      if (lens_rd_en) begin
         lens_rdata_ff <= lens_mem[rd_slot_ff];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_byte_valid     = rsp_bv_ff;
   assign rsp_run_last       = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_message_length = rsp_len_ff;
   assign rsp_queue_empty    = (rsp_count_ff == '0);
   assign rsp_message_count  = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C)
      else $error("stored message count exceeds the slot count");

   a_stream_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_STREAM |-> idx_ff < len_ff)
      else $error("stream index ran past the message length");

   a_byte_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bv_ff |-> rsp_status_ff == ST_OK && rsp_len_ff != '0)
      else $error("data byte delivered without an ok status and a length");

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      state_ff != BK_IDLE |-> !op_ready)
      else $error("operation taken while a pop is still in progress");

endmodule

FILE: design/message_slot_fifo.sv
// Message slot FIFO top level: a ring of fixed-size message slots.
// Instantiates msf_front and msf_back; depends on msf_pkg.
//
// Request channel (req_*): command 0 pushes one byte, with req_in_last on the
// final byte; command 1 pops the oldest message; command 2 drops it. Unused
// command codes are taken and ignored. Response channel (rsp_*): a final push
// byte gives one status transaction; a pop gives one transaction per byte,
// run_last on the last; a drop, a zero-length pop or an empty-queue pop or
// drop gives one. Non-final push bytes give no response.
// Throughput: push bytes are taken one per cycle while the back end is not busy
// with a pop or drop. A pop occupies it for a length lookup, then one byte-memory
// read per byte; a drop for the length lookup only. Every transaction passes
// through the two-entry operation queue. A final push byte or an empty-queue pop
// or drop enters the output register at the edge where the back end takes it, a
// drop or zero-length pop from BK_LEN and the first pop byte from BK_STREAM.
// Reset clears pointers, counts and queues; slot contents are not cleared and
// need no clearing pass. When the receiver stalls, the output register holds
// its transaction, the back end keeps taking non-final push bytes but waits on
// anything that answers, and the front queue fills and then deasserts req_ready.
module message_slot_fifo #(
   parameter int QUEUE_DEPTH = 16,
   parameter int MAX_MESSAGE = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_command,
   input  logic [7:0]                         req_in_byte,
   input  logic                               req_in_last,
   input  logic                               req_in_empty_message,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_byte_valid,
   output logic                               rsp_run_last,
   output logic [1:0]                         rsp_status,
   output logic [msf_pkg::LEN_W-1:0]          rsp_message_length,
   output logic                               rsp_queue_empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_message_count
);
   import msf_pkg::*;

   logic   op_valid;
   logic   op_ready;
   op_type op;

   msf_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_in_byte          (req_in_byte),
      .req_in_last          (req_in_last),
      .req_in_empty_message (req_in_empty_message),
      .op_valid             (op_valid),
      .op_ready             (op_ready),
      .op                   (op)
   );

   msf_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_MESSAGE (MAX_MESSAGE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .op_valid           (op_valid),
      .op_ready           (op_ready),
      .op                 (op),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_run_last       (rsp_run_last),
      .rsp_status         (rsp_status),
      .rsp_message_length (rsp_message_length),
      .rsp_queue_empty    (rsp_queue_empty),
      .rsp_message_count  (rsp_message_count)
   );

endmodule
